/* src/olist_pkg.sv */
// package with shared types and codes for the ordered list engine
package olist_pkg;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_PUSH   = 3'd1,
    OP_SEARCH = 3'd2,
    OP_POP    = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_MISS  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_COMPARE,
    CMD_APPEND,
    CMD_PUSH,
    CMD_POP,
    CMD_REMOVE
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    cell_cmd_t   cmd;
    logic [31:0] value;
  } cell_ctrl_t;

endpackage

/* src/olist_cell.sv */
// one list cell: holds an entry, its match flag, and moves data to or from its neighbors
module olist_cell import olist_pkg::*; (
  input  logic        clk,
  input  cell_ctrl_t  ctrl,
  input  logic        active,
  input  logic        is_tail,
  input  logic [31:0] left_data,
  input  logic [31:0] right_data,
  input  logic        hit_in,
  output logic [31:0] data,
  output logic        hit_out
);

  logic [31:0] data_r, data_nxt;
  logic        match_r, match_nxt;

  assign data    = data_r;
  assign hit_out = hit_in | match_r;

  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    unique case (ctrl.cmd)
      CMD_COMPARE: match_nxt = active && (data_r == ctrl.value);
      CMD_APPEND: begin
        if (is_tail) data_nxt = ctrl.value;
      end
      CMD_PUSH:   data_nxt = left_data;
      CMD_POP:    data_nxt = right_data;
      CMD_REMOVE: begin
        if (hit_out) data_nxt = right_data;
      end
      default: begin
        data_nxt  = data_r;
        match_nxt = match_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

endmodule

/* src/ordered_list_engine_core.sv */
// top level of the ordered list engine: control, count and the row of cells
// Usage:
//   A request (in_operation, in_value) transfers at a rising edge with start high and
//   busy low. Operations: append at tail, insert at head, search, remove head,
//   remove first entry equal to in_value.
//   On the transfer edge every cell compares its entry with in_value. The next
//   cycle (busy high) a first-match flag ripples down the row and the cells shift
//   left or right in one step. The result shows on out_found, out_status and
//   out_entry_count with out_valid high for exactly one cycle, the cycle after the
//   busy cycle.
//   A new request is not taken in the busy cycle, while the cell row shifts for the
//   previous one; it may transfer while the previous result is on the output.
//   The receiver cannot stall; each result is taken in its strobe cycle.
//   Reset (rst_n low, synchronous) empties the list and drops any request in flight;
//   entry storage is not cleared, only entries below the count are ever used.
module ordered_list_engine_core import olist_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic               out_found,
  output logic [1:0]         out_status,
  output logic [4:0]         out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);

  state_t         state_r, state_nxt;
  op_t            op_r, op_nxt;
  logic [31:0]    value_r, value_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_found_r, out_found_nxt;
  status_t        out_status_r, out_status_nxt;
  logic [4:0]     out_count_r, out_count_nxt;
  logic [CW+4:0]  count_ext;
  cell_ctrl_t     ctrl;
  logic           accept;
  logic           full;
  logic           empty;
  logic           found_all;

  logic [31:0]    cell_data [DEPTH];
  logic [DEPTH:0] hit_chain;

  assign hit_chain[0] = 1'b0;
  assign found_all    = hit_chain[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    olist_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .active     (CW'(i) < count_r),
      .is_tail    (CW'(i) == count_r),
      .left_data  ((i == 0) ? ctrl.value : cell_data[(i == 0) ? 0 : i - 1]),
      .right_data ((i == DEPTH - 1) ? cell_data[i] : cell_data[(i == DEPTH - 1) ? i : i + 1]),
      .hit_in     (hit_chain[i]),
      .data       (cell_data[i]),
      .hit_out    (hit_chain[i+1])
    );
  end

  assign busy   = (state_r == ST_EXEC);
  assign accept = start && !busy;
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);

  assign count_ext = {5'b0, count_nxt};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    value_nxt      = value_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_found_nxt  = 1'b0;
    out_status_nxt = STS_OK;
    out_count_nxt  = out_count_r;
    ctrl.cmd       = CMD_HOLD;
    ctrl.value     = in_value;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ctrl.cmd  = CMD_COMPARE;
          op_nxt    = op_t'(in_operation);
          value_nxt = in_value;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl.value    = value_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        unique case (op_r)
          OP_APPEND: begin
            if (full) begin
              out_status_nxt = STS_FULL;
            end else begin
              ctrl.cmd  = CMD_APPEND;
              count_nxt = count_r + 1'b1;
            end
          end
          OP_PUSH: begin
            if (full) begin
              out_status_nxt = STS_FULL;
            end else begin
              ctrl.cmd  = CMD_PUSH;
              count_nxt = count_r + 1'b1;
            end
          end
          OP_SEARCH: begin
            out_found_nxt  = found_all;
            out_status_nxt = found_all ? STS_OK : STS_MISS;
          end
          OP_POP: begin
            if (empty) begin
              out_status_nxt = STS_EMPTY;
            end else begin
              ctrl.cmd  = CMD_POP;
              count_nxt = count_r - 1'b1;
            end
          end
          OP_REMOVE: begin
            if (empty) begin
              out_status_nxt = STS_EMPTY;
            end else if (found_all) begin
              ctrl.cmd      = CMD_REMOVE;
              count_nxt     = count_r - 1'b1;
              out_found_nxt = 1'b1;
            end else begin
              out_status_nxt = STS_MISS;
            end
          end
          default: out_status_nxt = STS_OK;
        endcase
        out_count_nxt = count_ext[4:0];
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    value_r      <= value_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

endmodule

/* src/olist_checker.sv */
// port-level assertions for the ordered list engine and their bind
module olist_checker import olist_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [2:0]         in_operation,
  input logic signed [31:0] in_value,
  input logic               out_valid,
  input logic               out_found,
  input logic [1:0]         out_status,
  input logic [4:0]         out_entry_count
);

  logic accept;
  assign accept = start && !busy;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after request transfer");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 (out_valid && !busy))
    else $error("result strobe missing two cycles after transfer");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept && rst_n, 2))
    else $error("result strobe without a request");

  a_found_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == STS_OK))
    else $error("hit reported with non-ok status");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STS_EMPTY) |-> (out_entry_count == 5'd0))
    else $error("empty status with nonzero count");

endmodule

bind ordered_list_engine_core olist_checker u_olist_checker (.*);
